>>> design/wheel_velocity_pid_defines.svh
// Assertion macros used by the wheel velocity PID top level.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef WHEEL_VELOCITY_PID_DEFINES_SVH
`define WHEEL_VELOCITY_PID_DEFINES_SVH

// Clocked check, muted while reset is held
`define WVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define WVP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/wvp_pkg.sv
// Package for the wheel velocity PID: widths, codes, state word and reset values.
// No dependencies; imported by wheel_velocity_pid.
`default_nettype none

package wvp_pkg;

  // Field and datapath widths
  localparam int VEL_W       = 16;          // Q7.8 velocity
  localparam int IN_DATA_W   = 2 * VEL_W;   // measured, desired
  localparam int ERR_W       = VEL_W + 1;   // |desired| - measured
  localparam int DERR_W      = ERR_W + 1;   // error change
  localparam int SUM_W       = 32;          // saturating error sum
  localparam int GAIN_W      = 8;
  localparam int PROD_W      = GAIN_W + 1 + DERR_W;    // P*e + D*de
  localparam int NUM_W       = PROD_W + GAIN_W + 1;    // (..)*I + sum
  localparam int FRAC_W      = 8;                      // Q7.8 fraction
  localparam int DIV_W       = NUM_W - FRAC_W;         // dividend after >>8
  localparam int DIV_CNT_W   = $clog2(DIV_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = GAIN_W;

  localparam int DEF_CORRECTION_LIMIT = 1023;

  // Register reset values
  localparam logic [GAIN_W-1:0] P_GAIN_RST    = 8'd25;
  localparam logic [GAIN_W-1:0] I_DIVISOR_RST = 8'd30;
  localparam logic [GAIN_W-1:0] D_GAIN_RST    = 8'd1;
  localparam logic [GAIN_W-1:0] DEADBAND_RST  = 8'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN    = 2'd0,
    CFG_I_DIVISOR = 2'd1,
    CFG_D_GAIN    = 2'd2,
    CFG_DEADBAND  = 2'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PE,
    ST_DE,
    ST_MI,
    ST_SETUP,
    ST_DIV,
    ST_OUT
  } wvp_state_t;

  // Per-wheel state word held in memory
  typedef struct packed {
    logic                    fwd;
    logic signed [ERR_W-1:0] last_err;
    logic signed [SUM_W-1:0] err_sum;
  } wheel_state_t;

  localparam wheel_state_t WHEEL_STATE_RST = '{fwd: 1'b1, last_err: '0, err_sum: '0};

endpackage

`default_nettype wire

>>> design/wheel_velocity_pid.sv
// Two-wheel velocity PID controller, top level.
// Depends on wvp_pkg and wheel_velocity_pid_defines.svh.
`default_nettype none

`include "wheel_velocity_pid_defines.svh"

// Each request names a wheel and carries measured and desired velocity
// (signed Q7.8). A request with a negative measurement is dropped on accept
// and yields no result. Otherwise the block reads the wheel's state word from
// a two-entry state memory, updates direction, saturating error sum and last
// error, writes the word back, then forms (P*e + D*de)*I + sum in three
// multiply steps and divides by 256*I with a one-bit-per-cycle
// restoring divider. From accept to result a request passes through the
// memory read, the state update, the three multiply steps, the divider
// setup, one divider step per quotient bit and the output load. Requests
// are handled one at a time; the result sits in an output register so the
// next request can be taken while it waits. Configuration writes are always
// accepted and must come only while the block is idle.
module wheel_velocity_pid import wvp_pkg::*; #(
  parameter int  CORRECTION_LIMIT = DEF_CORRECTION_LIMIT,
  localparam int CORR_W           = $clog2(CORRECTION_LIMIT + 1) + 1,
  localparam int OUT_DATA_W       = ((CORR_W + 2 + 7) / 8) * 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input request channel
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [IN_DATA_W-1:0]   in_tdata,   // [15:0] measured_velocity, [31:16] desired_velocity
  input  wire                    in_tuser,   // [0] wheel
  // result channel
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [0] direction_write, [1] direction,
                                             // [CORR_W+1:2] correction, rest zero
  output logic                   out_tuser,  // [0] wheel_out
  // configuration write channel
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [GAIN_W-1:0] p_gain_r, i_divisor_r, d_gain_r, deadband_r;
  logic [GAIN_W-1:0] idiv_eff;

  // Sequencer
  wvp_state_t state_r, state_nxt;
  logic       in_accept, meas_neg, out_free, out_load;

  // State memory
  wheel_state_t mem_r [2];
  logic [1:0]   valid_r;
  wheel_state_t rd_r, rd_state;
  logic         rd_vld_r;

  // Request registers
  logic                    wheel_r;
  logic [VEL_W-1:0]        meas_r, des_r;

  // Update step
  logic signed [ERR_W-1:0]  des_x, abs_des, err_calc, err_mag;
  logic signed [DERR_W-1:0] derr_calc;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic                     des_pos, des_neg, fwd_new;

  // Arithmetic registers
  logic signed [ERR_W-1:0]  e_r;
  logic signed [DERR_W-1:0] de_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     fwd_r, dirw_r, dead_r;
  logic signed [PROD_W-1:0] t_r;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [PROD_W-2:0] pe_prod;
  logic signed [PROD_W-1:0] de_prod;
  logic signed [NUM_W-1:0]  num_calc, num_abs;

  // Divider
  logic [DIV_W-1:0]     quo_r;
  logic [GAIN_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 neg_r;
  logic [GAIN_W:0]      rem_shift;
  logic                 q_bit;

  // Result
  logic [CORR_W-2:0]    q_clamp;
  logic [CORR_W-1:0]    corr;
  logic                 out_valid_r;
  logic                 out_user_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r    <= P_GAIN_RST;
      i_divisor_r <= I_DIVISOR_RST;
      d_gain_r    <= D_GAIN_RST;
      deadband_r  <= DEADBAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_P_GAIN:    p_gain_r    <= cfg_data;
        CFG_I_DIVISOR: i_divisor_r <= cfg_data;
        CFG_D_GAIN:    d_gain_r    <= cfg_data;
        CFG_DEADBAND:  deadband_r  <= cfg_data;
      endcase
    end
  end

  // A zero divisor acts as one
  assign idiv_eff = (i_divisor_r == '0) ? GAIN_W'(1) : i_divisor_r;

  // Handshake and sequencer
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign meas_neg  = in_tdata[VEL_W-1];
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (in_accept && !meas_neg) begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD:  state_nxt = ST_PE;
      ST_PE:    state_nxt = ST_DE;
      ST_DE:    state_nxt = ST_MI;
      ST_MI:    state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_DIV;
      ST_DIV:   if (div_cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        state_nxt = ST_OUT;
      end
      ST_OUT:   if (out_free) begin
        out_load  = 1'b1;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the request and read its wheel's state word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      wheel_r  <= in_tuser;
      meas_r   <= in_tdata[VEL_W-1:0];
      des_r    <= in_tdata[IN_DATA_W-1:VEL_W];
      rd_r     <= mem_r[in_tuser];
      rd_vld_r <= valid_r[in_tuser];
    end
  end

  // Unwritten entries read as the reset state
  assign rd_state = rd_vld_r ? rd_r : WHEEL_STATE_RST;

  // Error, direction and saturating sum
  always_comb begin
    des_x     = $signed({des_r[VEL_W-1], des_r});
    abs_des   = des_r[VEL_W-1] ? -des_x : des_x;
    err_calc  = abs_des - $signed({1'b0, meas_r});
    err_mag   = err_calc[ERR_W-1] ? -err_calc : err_calc;
    derr_calc = $signed({err_calc[ERR_W-1], err_calc})
              - $signed({rd_state.last_err[ERR_W-1], rd_state.last_err});
    sum_ext   = $signed({rd_state.err_sum[SUM_W-1], rd_state.err_sum})
              + $signed({{(SUM_W + 1 - ERR_W){err_calc[ERR_W-1]}}, err_calc});
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? $signed({1'b1, {(SUM_W - 1){1'b0}}})
                               : $signed({1'b0, {(SUM_W - 1){1'b1}}});
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
    des_pos = !des_r[VEL_W-1] && (des_r != '0);
    des_neg = des_r[VEL_W-1];
    fwd_new = des_pos ? 1'b1 : (des_neg ? 1'b0 : rd_state.fwd);
  end

  // Write the updated state word back
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      mem_r[wheel_r] <= '{fwd: fwd_new, last_err: err_calc, err_sum: sum_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (state_r == ST_LOAD) begin
      valid_r[wheel_r] <= 1'b1;
    end
  end

  // Multiply steps
  assign pe_prod  = $signed({1'b0, p_gain_r}) * e_r;
  assign de_prod  = $signed({1'b0, d_gain_r}) * de_r;
  assign num_calc = t_r * $signed({1'b0, idiv_eff})
                  + $signed({{(NUM_W - SUM_W){sum_r[SUM_W-1]}}, sum_r});
  assign num_abs  = num_r[NUM_W-1] ? -num_r : num_r;

  // One restoring divide step
  assign rem_shift = {rem_r, quo_r[DIV_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, idiv_eff});

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_LOAD: begin
        e_r    <= err_calc;
        de_r   <= derr_calc;
        sum_r  <= sum_sat;
        fwd_r  <= fwd_new;
        dirw_r <= (fwd_new != rd_state.fwd);
        dead_r <= ($unsigned(err_mag) < {{(ERR_W - GAIN_W){1'b0}}, deadband_r});
      end
      ST_PE:    t_r   <= $signed({pe_prod[PROD_W-2], pe_prod});
      ST_DE:    t_r   <= t_r + de_prod;
      ST_MI:    num_r <= num_calc;
      ST_SETUP: begin
        neg_r     <= num_r[NUM_W-1];
        quo_r     <= num_abs[NUM_W-1:FRAC_W];
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r     <= q_bit ? GAIN_W'(rem_shift - {1'b0, idiv_eff}) : rem_shift[GAIN_W-1:0];
        quo_r     <= {quo_r[DIV_W-2:0], q_bit};
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Clamp, restore sign, apply deadband
  always_comb begin
    if (quo_r > DIV_W'(CORRECTION_LIMIT)) begin
      q_clamp = (CORR_W - 1)'(CORRECTION_LIMIT);
    end else begin
      q_clamp = quo_r[CORR_W-2:0];
    end
    if (dead_r) begin
      corr = '0;
    end else if (neg_r) begin
      corr = -{1'b0, q_clamp};
    end else begin
      corr = {1'b0, q_clamp};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_user_r <= wheel_r;
      out_data_r <= OUT_DATA_W'({corr, fwd_r, dirw_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  // Checks
  `WVP_ASSERT(a_take_goes_load, in_accept && !meas_neg |=> state_r == ST_LOAD, "accepted request did not start")
  `WVP_ASSERT(a_div_ends, state_r == ST_DIV && div_cnt_r == DIV_CNT_W'(DIV_W - 1) |=> state_r == ST_OUT, "divider overran")
  `WVP_ASSERT(a_out_blocked, state_r == ST_OUT && out_valid_r && !out_tready |=> state_r == ST_OUT && out_valid_r, "result overwrote pending output")
  `WVP_ASSERT(a_wb_valid, state_r == ST_LOAD |=> valid_r[wheel_r], "state word not marked written")
  `WVP_ASSERT(a_dead_zero, out_load && dead_r |=> out_tdata[CORR_W+1:2] == '0, "deadband result not zero")

endmodule

`default_nettype wire
